>>> rtl/mrfc_pkg.sv
`timescale 1ns / 1ps

package mrfc_pkg;

  localparam int unsigned HDR_BYTES  = 7;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PADDR_W    = 3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] READ_BYTE_COUNT = 8'h04;
  localparam logic [7:0] REG_SWITCH      = 8'h01;
  localparam logic [7:0] REG_VOLTAGE     = 8'h30;

  localparam logic [7:0] SLAVE_ADDR_RST  = 8'h01;

  // Register indexes on the configuration port.
  localparam logic [PADDR_W-3:0] REG_SLAVE_ADDRESS = '0;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_SWITCH   = 2'd1,
    KIND_VOLTAGE  = 2'd2,
    KIND_READBACK = 2'd3
  } frame_kind_e;

  // One finished frame as handed from the byte collector to the classifier.
  typedef struct packed {
    logic                           crc_ok;
    logic                           short_frame;
    logic [HDR_BYTES-1:0][7:0]      hdr;
  } frame_rec_t;

  typedef struct packed {
    logic        crc_ok;
    logic        short_frame;
    frame_kind_e kind;
    logic [15:0] first_value;
    logic [15:0] second_value;
  } result_t;

  // Byte-wide unrolled Modbus CRC-16 update.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/mrfc_front.sv
`timescale 1ns / 1ps

module mrfc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    end_of_frame_i,
  output logic                    rec_push_o,
  output mrfc_pkg::frame_rec_t    rec_o
);

  logic [15:0] crc_q, crc_d, crc_upd;
  logic [15:0] tail_q, tail_d, tail_upd;
  logic [mrfc_pkg::HDR_BYTES-1:0][7:0] hdr_q, hdr_d, hdr_upd;
  logic [3:0]  cnt_q, cnt_d, cnt_upd;

  always_comb begin
    // The oldest tail byte can no longer be part of the trailing CRC word.
    crc_upd  = (cnt_q >= 4'd2) ? mrfc_pkg::crc_byte(crc_q, tail_q[7:0]) : crc_q;
    tail_upd = {data_byte_i, tail_q[15:8]};
    hdr_upd  = hdr_q;
    if (cnt_q < 4'(mrfc_pkg::HDR_BYTES)) begin
      hdr_upd[cnt_q[2:0]] = data_byte_i;
    end
    cnt_upd  = (cnt_q < 4'd8) ? cnt_q + 4'd1 : cnt_q;
  end

  always_comb begin
    crc_d  = crc_q;
    tail_d = tail_q;
    hdr_d  = hdr_q;
    cnt_d  = cnt_q;
    if (accept_i) begin
      if (end_of_frame_i) begin
        crc_d  = mrfc_pkg::CRC_INIT;
        tail_d = '0;
        hdr_d  = '0;
        cnt_d  = '0;
      end else begin
        crc_d  = crc_upd;
        tail_d = tail_upd;
        hdr_d  = hdr_upd;
        cnt_d  = cnt_upd;
      end
    end
  end

  always_comb begin
    rec_push_o        = accept_i && end_of_frame_i;
    rec_o.short_frame = (cnt_upd < 4'd3);
    rec_o.crc_ok      = !rec_o.short_frame && (crc_upd == tail_upd);
    rec_o.hdr         = hdr_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= mrfc_pkg::CRC_INIT;
      tail_q <= '0;
      hdr_q  <= '0;
      cnt_q  <= '0;
    end else begin
      crc_q  <= crc_d;
      tail_q <= tail_d;
      hdr_q  <= hdr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> rtl/mrfc_fifo.sv
`timescale 1ns / 1ps

module mrfc_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  mrfc_pkg::frame_rec_t    wdata_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output mrfc_pkg::frame_rec_t    rdata_o,
  output logic                    empty_o
);

  mrfc_pkg::frame_rec_t mem_q [mrfc_pkg::FIFO_DEPTH];
  logic [mrfc_pkg::PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mrfc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  always_comb begin
    full_o   = (cnt_q == mrfc_pkg::CNT_W'(mrfc_pkg::FIFO_DEPTH));
    empty_o  = (cnt_q == '0);
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    rdata_o  = mem_q[rd_ptr_q];
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/mrfc_back.sv
`timescale 1ns / 1ps

module mrfc_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [7:0]              slave_addr_i,
  input  mrfc_pkg::frame_rec_t    rec_i,
  input  logic                    rec_empty_i,
  output logic                    rec_pop_o,
  output mrfc_pkg::result_t       res_o,
  output logic                    res_valid_o,
  input  logic                    res_pop_i
);

  mrfc_pkg::result_t res_q, res_d;
  logic              valid_q, valid_d;
  logic              addr_ok;

  always_comb begin
    res_d.crc_ok       = rec_i.crc_ok;
    res_d.short_frame  = rec_i.short_frame;
    res_d.kind         = mrfc_pkg::KIND_NONE;
    res_d.first_value  = '0;
    res_d.second_value = '0;
    addr_ok = rec_i.crc_ok && (rec_i.hdr[0] == slave_addr_i);
    if (addr_ok) begin
      if (rec_i.hdr[1] == mrfc_pkg::FC_WRITE_SINGLE && rec_i.hdr[3] == mrfc_pkg::REG_SWITCH) begin
        res_d.kind        = mrfc_pkg::KIND_SWITCH;
        res_d.first_value = {rec_i.hdr[4], rec_i.hdr[5]};
      end else if (rec_i.hdr[1] == mrfc_pkg::FC_WRITE_SINGLE &&
                   rec_i.hdr[3] == mrfc_pkg::REG_VOLTAGE) begin
        res_d.kind        = mrfc_pkg::KIND_VOLTAGE;
        res_d.first_value = {rec_i.hdr[4], rec_i.hdr[5]};
      end else if (rec_i.hdr[1] == mrfc_pkg::FC_READ_HOLDING &&
                   rec_i.hdr[2] == mrfc_pkg::READ_BYTE_COUNT) begin
        res_d.kind         = mrfc_pkg::KIND_READBACK;
        res_d.first_value  = {rec_i.hdr[3], rec_i.hdr[4]};
        res_d.second_value = {rec_i.hdr[5], rec_i.hdr[6]};
      end
    end
  end

  // The output register refills in the same cycle its beat is taken.
  always_comb begin
    rec_pop_o = !rec_empty_i && (!valid_q || res_pop_i);
    valid_d   = rec_pop_o ? 1'b1 : (res_pop_i ? 1'b0 : valid_q);
  end

  assign res_o       = res_q;
  assign res_valid_o = valid_q;

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

>>> rtl/modbus_reply_frame_checker.sv
`timescale 1ns / 1ps

// Modbus RTU reply checker: takes one reply byte per beat, runs the Modbus CRC-16 over all
// but the trailing two bytes and, on the byte marked end_of_frame_i, gives one result with
// the CRC verdict, a short-frame flag, the reply kind and its two values. Bytes are taken
// at one per cycle, back to back, while full is low, set by the byte-wide CRC update in
// the collector. A finished frame passes through a two-entry queue to the classifier,
// whose output register takes the result once it is free; full stays low as long as that
// queue has room, so bytes keep flowing while results wait to be popped.
module modbus_reply_frame_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrfc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    data_byte_i,
  input  logic                          end_of_frame_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          crc_ok_o,
  output logic                          short_frame_o,
  output logic [1:0]                    frame_kind_o,
  output logic [15:0]                   first_value_o,
  output logic [15:0]                   second_value_o
);

  logic [7:0]           slave_addr_q, slave_addr_d;
  logic                 reg_hit;
  logic                 accept;
  logic                 rec_push, rec_pop, rec_empty;
  mrfc_pkg::frame_rec_t rec_in, rec_out;
  mrfc_pkg::result_t    res;
  logic                 res_valid;

  always_comb begin
    reg_hit      = (paddr[mrfc_pkg::PADDR_W-1:2] == mrfc_pkg::REG_SLAVE_ADDRESS);
    slave_addr_d = slave_addr_q;
    if (psel && penable && pwrite && reg_hit) begin
      slave_addr_d = pwdata[7:0];
    end
    prdata = reg_hit ? {24'h000000, slave_addr_q} : '0;
    pready = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= mrfc_pkg::SLAVE_ADDR_RST;
    end else begin
      slave_addr_q <= slave_addr_d;
    end
  end

  assign accept = push && !full;

  mrfc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .rec_push_o     (rec_push),
    .rec_o          (rec_in)
  );

  mrfc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_in),
    .full_o  (full),
    .pop_i   (rec_pop),
    .rdata_o (rec_out),
    .empty_o (rec_empty)
  );

  mrfc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slave_addr_i (slave_addr_q),
    .rec_i        (rec_out),
    .rec_empty_i  (rec_empty),
    .rec_pop_o    (rec_pop),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop && !empty)
  );

  always_comb begin
    empty          = !res_valid;
    crc_ok_o       = res.crc_ok;
    short_frame_o  = res.short_frame;
    frame_kind_o   = res.kind;
    first_value_o  = res.first_value;
    second_value_o = res.second_value;
  end

endmodule
